// ----- rtl/core/graph_bfs_dfs_path_engine_top_assert.svh -----
// Assertion macros for the graph path engine.
`ifndef GRAPH_BFS_DFS_PATH_ENGINE_TOP_ASSERT_SVH
`define GRAPH_BFS_DFS_PATH_ENGINE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GPE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define GPE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define GPE_ASSERT_IMPL(label, ante, cons)
`define GPE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/gpe_pkg.sv -----
// Shared types and codes of the graph path engine.
package gpe_pkg;
	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_DFS = 2'd1;
	localparam logic [1:0] KIND_BFS = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [2:0] ST_ADDED = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_FOUND = 3'd2;
	localparam logic [2:0] ST_UNREACH = 3'd3;
	localparam logic [2:0] ST_RANGE = 3'd4;
	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_ADD1  = 12'b000000000010,
		S_CLR   = 12'b000000000100,
		S_POP   = 12'b000000001000,
		S_POPW  = 12'b000000010000,
		S_NBR   = 12'b000000100000,
		S_NBRW  = 12'b000001000000,
		S_HOP   = 12'b000010000000,
		S_HOPW  = 12'b000100000000,
		S_EMIT  = 12'b001000000000,
		S_EMITW = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} state_t;
endpackage

// ----- rtl/core/graph_bfs_dfs_path_engine_top.sv -----
// Top level of the graph path engine: edge store, walk sequencer and result register.
// Usage: items enter on valid/ready with kind, node_a and node_b; results leave on
// out_valid/out_ready with status, path_vertex, hop_count and last. The
// vertex_count register is written through cfg_we and cfg_wdata; the user must write it
// only while idle, which the block itself does not enforce. An add-edge word passes
// through S_ADD1 and S_OUT before its result is registered. A query first clears the
// visited marks, then walks: each popped vertex passes through S_POP, S_POPW and S_NBR
// and each neighbor entry through S_NBRW and S_NBR, all through one neighbor memory
// read port. A path result then walks the parent links twice, once in S_HOP/S_HOPW to
// count the hops and once in S_EMIT/S_EMITW to hand out one vertex per word. The block
// takes no new word until the last result of the current one has been taken. A
// stalled receiver holds the result register and the sequencer.
// Reset clears the degree counts and sets vertex_count to 64; the neighbor memory,
// parent links and work list need no reset since they are written before read.
module graph_bfs_dfs_path_engine_top #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_DEGREE = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       valid,
	output logic       ready,
	input  logic [1:0] kind,
	input  logic [5:0] node_a,
	input  logic [5:0] node_b,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic [5:0] path_vertex,
	output logic [5:0] hop_count,
	output logic       last
);
	import gpe_pkg::*;

	localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int CW = $clog2(MAX_DEGREE + 1);
	localparam int WW = $clog2(MAX_VERTICES + 2);
	localparam int MD = MAX_VERTICES * MAX_DEGREE;
	localparam int AW = $clog2(MD);

	logic [5:0] nbr_mem [MD];
	logic [5:0] par_mem [MAX_VERTICES];
	logic [5:0] wl_mem [MAX_VERTICES + 1];
	logic [CW-1:0] deg_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] deg_vld_q;
	logic [MAX_VERTICES-1:0] vis_q;

	state_t state_q;
	logic [6:0] vcount_q;
	logic [1:0] kind_q;
	logic [5:0] a_q, b_q, cur_q, hops_q, k_q;
	logic [WW-1:0] head_q, tail_q;
	logic [CW-1:0] idx_q;
	logic [5:0] nbr_rd_q, par_rd_q, wl_rd_q;
	logic [CW-1:0] deg_rd_a_q, deg_rd_b_q;
	logic [6:0] n_use;

	assign n_use = (vcount_q > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_q;

	logic [CW-1:0] deg_a, deg_b, deg_cur, deg_b_now;
	assign deg_a = deg_rd_a_q;
	assign deg_b = deg_rd_b_q;
	assign deg_cur = deg_rd_a_q;
	assign deg_b_now = (a_q == b_q) ? CW'(deg_a + 1'b1) : deg_b;

	logic add_ok;
	always_comb begin
		if (a_q == b_q) add_ok = (32'(deg_a) + 2) <= MAX_DEGREE;
		else add_ok = (32'(deg_a) + 1) <= MAX_DEGREE && (32'(deg_b) + 1) <= MAX_DEGREE;
	end

	logic is_dfs;
	assign is_dfs = (kind_q == KIND_DFS);

	// Memory ports driven by the sequencer.
	logic nbr_we;
	logic [AW-1:0] nbr_wa, nbr_ra;
	logic [5:0] nbr_wd;
	logic wl_we;
	logic [WW-1:0] wl_wa, wl_ra;
	logic [5:0] wl_wd;
	logic par_we;
	logic [5:0] par_wd;
	logic [VW-1:0] par_wa, par_ra;
	logic deg_we, deg_rd_en;
	logic [VW-1:0] deg_wa, deg_ra_a, deg_ra_b;
	logic [CW-1:0] deg_wd;

	always_ff @(posedge clk) begin
		if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
		nbr_rd_q <= nbr_mem[nbr_ra];
		if (wl_we) wl_mem[wl_wa] <= wl_wd;
		wl_rd_q <= wl_mem[wl_ra];
		if (par_we) par_mem[par_wa] <= par_wd;
		par_rd_q <= par_mem[par_ra];
		if (deg_we) deg_mem[deg_wa] <= deg_wd;
		if (deg_rd_en) deg_rd_a_q <= deg_vld_q[deg_ra_a] ? deg_mem[deg_ra_a] : '0;
		if (state_q == S_IDLE && valid && ready)
			deg_rd_b_q <= deg_vld_q[deg_ra_b] ? deg_mem[deg_ra_b] : '0;
	end

	always_comb begin
		deg_we = (state_q == S_ADD1 && add_ok)
			|| (state_q == S_OUT && kind_q == KIND_ADD && idx_q[0]);
		deg_wa = (state_q == S_ADD1) ? a_q[VW-1:0] : b_q[VW-1:0];
		deg_wd = (state_q == S_ADD1) ? CW'(deg_a + 1'b1) : CW'(deg_b_now + 1'b1);
		deg_rd_en = (state_q == S_IDLE && valid && ready) || state_q == S_POPW;
		deg_ra_a = (state_q == S_IDLE) ? node_a[VW-1:0] : wl_rd_q[VW-1:0];
		deg_ra_b = node_b[VW-1:0];
	end

	logic nb_take;
	assign nb_take = ({1'b0, nbr_rd_q} < n_use) && !vis_q[nbr_rd_q[VW-1:0]]
		&& (32'(tail_q) < MAX_VERTICES + 1);

	always_comb begin
		nbr_we = 1'b0;
		nbr_wa = '0;
		nbr_wd = '0;
		if (state_q == S_IDLE && valid && ready) begin
			nbr_we = 1'b0;
		end else if (state_q == S_ADD1 && add_ok) begin
			nbr_we = 1'b1;
			nbr_wa = AW'(a_q[VW-1:0] * MAX_DEGREE + 32'(deg_a));
			nbr_wd = b_q;
		end else if (state_q == S_OUT && kind_q == KIND_ADD && idx_q[0]) begin
			nbr_we = 1'b1;
			nbr_wa = AW'(b_q[VW-1:0] * MAX_DEGREE + 32'(deg_b_now));
			nbr_wd = a_q;
		end
		nbr_ra = AW'(cur_q[VW-1:0] * MAX_DEGREE + 32'(idx_q[DW-1:0]));
		wl_we = (state_q == S_CLR && 32'(k_q) == MAX_VERTICES - 1)
			|| (state_q == S_NBRW && nb_take);
		wl_wa = (state_q == S_CLR) ? '0 : tail_q;
		wl_wd = (state_q == S_CLR) ? a_q : nbr_rd_q;
		wl_ra = is_dfs ? WW'(tail_q - 1'b1) : head_q;
		par_we = (state_q == S_CLR && 32'(k_q) == MAX_VERTICES - 1)
			|| (state_q == S_NBRW && nb_take);
		par_wa = (state_q == S_CLR) ? a_q[VW-1:0] : nbr_rd_q[VW-1:0];
		par_wd = (state_q == S_CLR) ? a_q : cur_q;
		par_ra = cur_q[VW-1:0];
	end

	logic [2:0] st_q;
	logic [5:0] pv_q, hc_q;
	logic last_q, ov_q;
	logic out_free;
	assign out_free = !ov_q || out_ready;
	assign ready = (state_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign status = st_q;
	assign path_vertex = pv_q;
	assign hop_count = hc_q;
	assign last = last_q;

	always_ff @(posedge clk) begin
		if (nbr_we && state_q == S_OUT) idx_q <= '0;
		unique case (state_q)
			S_IDLE: idx_q <= '0;
			S_ADD1: idx_q <= CW'(add_ok);
			S_NBRW: idx_q <= CW'(idx_q + 1'b1);
			S_POPW: idx_q <= '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vcount_q <= 7'd64;
			ov_q <= 1'b0;
			vis_q <= '0;
			deg_vld_q <= '0;
		end else begin
			if (cfg_we) vcount_q <= cfg_wdata;
			if (ov_q && out_ready && state_q != S_EMIT) ov_q <= 1'b0;
			if (deg_we) deg_vld_q[deg_wa] <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (valid && ready) begin
						kind_q <= kind;
						a_q <= node_a;
						b_q <= node_b;
						cur_q <= node_a;
						k_q <= '0;
						if (kind == KIND_NONE) begin
							state_q <= S_IDLE;
						end else if ({1'b0, node_a} >= n_use || {1'b0, node_b} >= n_use) begin
							st_q <= ST_RANGE; pv_q <= '0; hc_q <= '0; last_q <= 1'b1;
							ov_q <= 1'b1;
						end else if (kind == KIND_ADD) begin
							state_q <= S_ADD1;
						end else begin
							state_q <= S_CLR;
						end
					end
				end
				S_ADD1: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (kind_q == KIND_ADD) begin
						if (idx_q[0]) st_q <= ST_ADDED;
						else st_q <= ST_FULL;
						pv_q <= '0; hc_q <= '0; last_q <= 1'b1;
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (out_free) begin
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CLR: begin
					vis_q[k_q[VW-1:0]] <= (k_q == a_q) && !is_dfs;
					k_q <= k_q + 1'b1;
					if (32'(k_q) == MAX_VERTICES - 1) begin
						state_q <= S_POP;
						head_q <= '0;
						tail_q <= WW'(1);
					end
				end
				S_POP: begin
					if ((is_dfs && tail_q == '0) || (!is_dfs && head_q == tail_q)) begin
						st_q <= ST_UNREACH; pv_q <= '0; hc_q <= '0; last_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						if (is_dfs) tail_q <= WW'(tail_q - 1'b1);
						else head_q <= WW'(head_q + 1'b1);
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					cur_q <= wl_rd_q;
					if (wl_rd_q == b_q) begin
						if (is_dfs) begin
							st_q <= ST_FOUND; pv_q <= '0; hc_q <= '0; last_q <= 1'b1;
							state_q <= S_OUT;
						end else begin
							hops_q <= '0;
							state_q <= S_HOP;
						end
					end else begin
						state_q <= S_NBR;
					end
				end
				S_NBR: begin
					if (idx_q < deg_cur && 32'(idx_q) < MAX_DEGREE) state_q <= S_NBRW;
					else state_q <= S_POP;
				end
				S_NBRW: begin
					if (nb_take) begin
						vis_q[nbr_rd_q[VW-1:0]] <= 1'b1;
						tail_q <= WW'(tail_q + 1'b1);
					end
					state_q <= S_NBR;
				end
				S_HOP: begin
					if (cur_q != a_q && 32'(hops_q) < MAX_VERTICES - 1) state_q <= S_HOPW;
					else begin
						cur_q <= b_q;
						k_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_HOPW: begin
					cur_q <= par_rd_q;
					hops_q <= hops_q + 1'b1;
					state_q <= S_HOP;
				end
				S_EMIT: begin
					if (out_free) begin
						st_q <= ST_FOUND; pv_q <= cur_q; hc_q <= hops_q;
						last_q <= (k_q == hops_q);
						ov_q <= 1'b1;
						if (k_q == hops_q) state_q <= S_IDLE;
						else state_q <= S_EMITW;
					end
				end
				S_EMITW: begin
					cur_q <= par_rd_q;
					k_q <= k_q + 1'b1;
					state_q <= S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`include "graph_bfs_dfs_path_engine_top_assert.svh"
	`GPE_ASSERT_IMPL(a_ready_idle, ready, state_q == S_IDLE)
	`GPE_ASSERT_IMPL(a_path_vertex, out_valid && status != ST_FOUND, path_vertex == 6'd0)
	`GPE_ASSERT_NEXT(a_one_hot, 1'b1, $onehot(state_q))
endmodule

// ----- sim/graph_bfs_dfs_path_engine_top_tb.sv -----
// Self-checking testbench for the graph path engine: random and directed words, predicted results.
`timescale 1ns / 100ps
module graph_bfs_dfs_path_engine_top_tb;
	import gpe_pkg::*;

	localparam int NV = 64;
	localparam int ND = 8;

	typedef struct {
		logic [1:0] kind;
		logic [5:0] a;
		logic [5:0] b;
	} request_t;

	typedef struct {
		logic [2:0] st;
		logic [5:0] pv;
		logic [5:0] hops;
		logic lst;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = 7'd0;
	logic valid = 1'b0;
	logic ready;
	logic [1:0] kind = 2'd0;
	logic [5:0] node_a = 6'd0;
	logic [5:0] node_b = 6'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [5:0] path_vertex;
	logic [5:0] hop_count;
	logic last;

	request_t pending_words[$];
	answer_t expected_words[$];
	int errors = 0;
	int words_seen = 0;
	bit quiet = 0;

	logic [5:0] adj [NV][ND];
	int degree [NV];
	int vcount = 64;
	bit seen_mark [NV];
	int parent_of [NV];
	int walk_list [NV + 1];

	graph_bfs_dfs_path_engine_top u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.valid(valid), .ready(ready), .kind(kind), .node_a(node_a), .node_b(node_b),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.path_vertex(path_vertex), .hop_count(hop_count), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic push_answer(logic [2:0] st, logic [5:0] pv, logic [5:0] hops, logic lst);
		answer_t r;
		r.st = st;
		r.pv = pv;
		r.hops = hops;
		r.lst = lst;
		expected_words = {expected_words, r};
	endtask

	function automatic logic [2:0] link_nodes(int a, int b);
		int need_a;
		need_a = (a == b) ? 2 : 1;
		if (degree[a] + need_a > ND || degree[b] + 1 > ND)
			return ST_FULL;
		adj[a][degree[a]] = b[5:0];
		degree[a]++;
		adj[b][degree[b]] = a[5:0];
		degree[b]++;
		return ST_ADDED;
	endfunction

	function automatic bit reach_depth(int src, int dst, int n);
		int top;
		int cur;
		int nb;
		top = 0;
		foreach (seen_mark[i]) seen_mark[i] = 0;
		walk_list[top++] = src;
		while (top > 0) begin
			cur = walk_list[--top];
			if (cur == dst)
				return 1;
			for (int i = 0; i < degree[cur] && i < ND; i++) begin
				nb = int'(adj[cur][i]);
				if (nb < n && !seen_mark[nb] && top < NV + 1) begin
					seen_mark[nb] = 1;
					walk_list[top++] = nb;
				end
			end
		end
		return 0;
	endfunction

	function automatic bit reach_breadth(int src, int dst, int n);
		int head;
		int tail;
		int cur;
		int nb;
		head = 0;
		tail = 0;
		foreach (seen_mark[i]) seen_mark[i] = 0;
		seen_mark[src] = 1;
		parent_of[src] = src;
		walk_list[tail++] = src;
		while (head < tail) begin
			cur = walk_list[head++];
			if (cur == dst)
				return 1;
			for (int i = 0; i < degree[cur] && i < ND; i++) begin
				nb = int'(adj[cur][i]);
				if (nb < n && !seen_mark[nb] && tail < NV + 1) begin
					seen_mark[nb] = 1;
					parent_of[nb] = cur;
					walk_list[tail++] = nb;
				end
			end
		end
		return 0;
	endfunction

	task automatic predict_answers(logic [1:0] k, logic [5:0] a, logic [5:0] b);
		int n;
		int hops;
		int cur;
		int ia;
		int ib;
		n = (vcount > NV) ? NV : vcount;
		ia = int'(a);
		ib = int'(b);
		if (k == KIND_NONE)
			return;
		if (ia >= n || ib >= n)
			push_answer(ST_RANGE, 6'd0, 6'd0, 1'b1);
		else if (k == KIND_ADD)
			push_answer(link_nodes(ia, ib), 6'd0, 6'd0, 1'b1);
		else if (k == KIND_DFS)
			push_answer(reach_depth(ia, ib, n) ? ST_FOUND : ST_UNREACH, 6'd0, 6'd0, 1'b1);
		else if (!reach_breadth(ia, ib, n))
			push_answer(ST_UNREACH, 6'd0, 6'd0, 1'b1);
		else begin
			hops = 0;
			cur = ib;
			while (cur != ia && hops < NV - 1) begin
				cur = parent_of[cur];
				hops++;
			end
			cur = ib;
			for (int i = 0; i <= hops; i++) begin
				push_answer(ST_FOUND, cur[5:0], hops[5:0], i == hops);
				cur = parent_of[cur];
			end
		end
	endtask

	task automatic report(string what, int got, int want);
		$display("mismatch in %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic queue_word(logic [1:0] k, logic [5:0] a, logic [5:0] b);
		request_t w;
		w.kind = k;
		w.a = a;
		w.b = b;
		pending_words = {pending_words, w};
	endtask

	task automatic queue_random(int count, int span);
		logic [1:0] k;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 9) k = KIND_ADD;
			else if (pick < 13) k = KIND_DFS;
			else if (pick < 19) k = KIND_BFS;
			else k = KIND_NONE;
			if ($urandom_range(0, 9) == 0)
				queue_word(k, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			else
				queue_word(k, 6'($urandom_range(0, span - 1)),
					6'($urandom_range(0, span - 1)));
		end
	endtask

	task automatic settle_and_write(logic [6:0] value);
		wait (pending_words.size() == 0 && !valid && expected_words.size() == 0);
		repeat (60) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		vcount = int'(value);
	endtask

	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (valid && ready)
				predict_answers(kind, node_a, node_b);
			if (!valid || ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					request_t w;
					w = pending_words.pop_front();
					valid <= 1'b1;
					kind <= w.kind;
					node_a <= w.a;
					node_b <= w.b;
					if (!quiet && $urandom_range(0, 4) == 0)
						send_gap <= $urandom_range(1, 12);
				end else begin
					valid <= 1'b0;
				end
			end
		end
	end

	int recv_gap = 0;
	int long_hold = 0;
	bit held = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
			long_hold <= 0;
		end else begin
			if (out_valid && out_ready) begin
				answer_t e;
				words_seen <= words_seen + 1;
				if (expected_words.size() == 0)
					report("unexpected word status", int'(status), -1);
				else begin
					e = expected_words.pop_front();
					if (status !== e.st) report("status", int'(status), int'(e.st));
					if (path_vertex !== e.pv)
						report("path_vertex", int'(path_vertex), int'(e.pv));
					if (hop_count !== e.hops)
						report("hop_count", int'(hop_count), int'(e.hops));
					if (last !== e.lst) report("last", int'(last), int'(e.lst));
				end
			end
			if (long_hold > 0) begin
				long_hold <= long_hold - 1;
				out_ready <= 1'b0;
			end else if (!held && words_seen == 30) begin
				held <= 1;
				long_hold <= 400;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				recv_gap <= $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		foreach (degree[i]) degree[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 4; i++) queue_word(KIND_ADD, 6'(i), 6'(i + 1));
		queue_word(KIND_BFS, 6'd0, 6'd4);
		queue_word(KIND_BFS, 6'd4, 6'd0);
		queue_word(KIND_DFS, 6'd0, 6'd4);
		queue_word(KIND_DFS, 6'd0, 6'd63);
		queue_word(KIND_BFS, 6'd0, 6'd63);
		queue_word(KIND_BFS, 6'd2, 6'd2);
		queue_word(KIND_DFS, 6'd5, 6'd5);
		queue_word(KIND_ADD, 6'd63, 6'd63);
		for (int i = 0; i < 4; i++) queue_word(KIND_ADD, 6'd62, 6'd62);
		queue_word(KIND_ADD, 6'd62, 6'd62);
		queue_word(KIND_ADD, 6'd62, 6'd0);
		queue_word(KIND_ADD, 6'd0, 6'd62);
		queue_word(KIND_NONE, 6'd63, 6'd63);
		queue_word(KIND_ADD, 6'd63, 6'd4);
		queue_word(KIND_BFS, 6'd0, 6'd63);
		queue_word(KIND_DFS, 6'd63, 6'd1);

		settle_and_write(7'd127);
		queue_random(25, 16);
		settle_and_write(7'd12);
		queue_random(30, 12);
		settle_and_write(7'd0);
		queue_random(4, 4);
		settle_and_write(7'd1);
		queue_word(KIND_BFS, 6'd0, 6'd0);
		queue_word(KIND_DFS, 6'd0, 6'd0);
		queue_word(KIND_ADD, 6'd0, 6'd1);
		settle_and_write(7'd64);
		queue_random(15, 64);
		wait (pending_words.size() == 0);
		quiet = 1;
		queue_random(25, 24);

		wait (pending_words.size() == 0 && !valid && expected_words.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
